@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL that carries checks.
// No dependencies; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is asserted.
`define RAUH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// Condition that must never hold outside reset.
`define RAUH_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

@@ rtl/rauh_pkg.sv @@
// Types and constants of the random access handshake block.
// No dependencies; used by rauh_fsm and the top level.
package rauh_pkg;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SENDS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_RNTI = 2'd2;

	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_RESPONSE = 3'd1;
	localparam logic [2:0] CMD_RESOLVE = 3'd2;
	localparam logic [2:0] CMD_RESP_TMO = 3'd3;
	localparam logic [2:0] CMD_RESOLVE_TMO = 3'd4;
	localparam logic [2:0] CMD_FORCE_IDLE = 3'd5;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT_RESP = 2'd1;
	localparam logic [1:0] PH_WAIT_RESOLVE = 2'd2;
	localparam logic [1:0] PH_CONNECTED = 2'd3;

	localparam logic [1:0] ST_ACTED = 2'd0;
	localparam logic [1:0] ST_WRONG_PHASE = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	localparam logic KIND_PREAMBLE = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	localparam logic [7:0] MAX_SENDS_RST = 8'd10;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] event_rnti;
		logic [15:0] granted_crnti;
	} evt_t;

	typedef struct packed {
		logic        send_valid;
		logic        send_kind;
		logic [5:0]  send_preamble;
		logic [15:0] send_rnti;
		logic [7:0]  attempt_count;
		logic        state_changed;
		logic [1:0]  prior_phase;
		logic [1:0]  current_phase;
		logic [15:0] owned_crnti;
		logic [1:0]  status;
	} res_t;

	typedef struct packed {
		logic [5:0]  preamble_number;
		logic [7:0]  max_preamble_sends;
		logic [15:0] expected_response_rnti;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [7:0]  tx_attempts;
		logic [15:0] saved_ra_rnti;
		logic [15:0] saved_crnti;
	} state_t;

endpackage

@@ rtl/random_access_ue_handshake_unit.sv @@
// Terminal side of the four-message random access handshake: each accepted event item
// gives exactly one result item. The block takes one item per cycle while evt_stall is
// low; an item is registered in the event register on accept, decoded against the
// handshake state, and its result is registered in the result register once that is
// free or being drained. A stalled res holds the result and stalls evt once the event
// register is also full. The state compare and update lie between the two registers.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata; the
// user must write them only while no item is in flight, which the block does not
// enforce. Depends on rauh_pkg, rauh_fsm and assert_macros.svh.
`include "assert_macros.svh"

module random_access_ue_handshake_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             evt_valid,
	output logic                             evt_stall,
	input  rauh_pkg::evt_t                   evt,
	output logic                             res_valid,
	input  logic                             res_stall,
	output rauh_pkg::res_t                   res,
	input  logic                             cfg_we,
	input  logic [rauh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rauh_pkg::CFG_W-1:0]       cfg_wdata
);

	rauh_pkg::cfg_t   cfg_q;
	rauh_pkg::state_t state_q;
	rauh_pkg::state_t state_nxt;
	rauh_pkg::evt_t   evt_s1;
	rauh_pkg::res_t   res_nxt;
	rauh_pkg::res_t   res_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             adv;
	logic             s1_move;
	logic             res_exhausted;
	logic             exhaust_ok;
	logic             res_preamble;
	logic             preamble_ok;
	logic             res_sent;

	// result register free or being drained
	assign adv = !valid_s2 || !res_stall;
	assign evt_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_number <= '0;
			cfg_q.max_preamble_sends <= rauh_pkg::MAX_SENDS_RST;
			cfg_q.expected_response_rnti <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rauh_pkg::REG_PREAMBLE: cfg_q.preamble_number <= cfg_wdata[5:0];
				rauh_pkg::REG_MAX_SENDS: cfg_q.max_preamble_sends <= cfg_wdata[7:0];
				rauh_pkg::REG_EXP_RNTI: cfg_q.expected_response_rnti <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv || !valid_s1) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			evt_s1 <= evt;
		end
	end

	rauh_fsm u_fsm (
		.st  (state_q),
		.cfg (cfg_q),
		.evt (evt_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign res_valid = valid_s2;
	assign res = res_s2;

	assign s1_move = adv && valid_s1;
	assign res_exhausted = res_valid && res.status == rauh_pkg::ST_EXHAUSTED;
	assign exhaust_ok = res.current_phase == rauh_pkg::PH_IDLE && res.attempt_count == 8'd0
		&& !res.send_valid;
	assign res_sent = res_valid && res.send_valid;
	assign res_preamble = res_sent && res.send_kind == rauh_pkg::KIND_PREAMBLE;
	assign preamble_ok = res.current_phase == rauh_pkg::PH_WAIT_RESP
		&& res.attempt_count != 8'd0;

	`RAUH_ASSERT(a_phase_follows_result, clk, arst_n, s1_move |=> (state_q.phase == res_s2.current_phase))
	`RAUH_ASSERT(a_exhaust_to_idle, clk, arst_n, res_exhausted |-> exhaust_ok)
	`RAUH_ASSERT(a_preamble_waits, clk, arst_n, res_preamble |-> preamble_ok)
	`RAUH_ASSERT_NEVER(a_send_on_ignore, clk, arst_n, res_sent && res.status != rauh_pkg::ST_ACTED)

endmodule

@@ rtl/rauh_fsm.sv @@
// Next-state and result logic of the random access handshake for one item.
// Depends on rauh_pkg.
module rauh_fsm (
	input  rauh_pkg::state_t st,
	input  rauh_pkg::cfg_t   cfg,
	input  rauh_pkg::evt_t   evt,
	output rauh_pkg::state_t nxt,
	output rauh_pkg::res_t   res
);

	logic [8:0] next_cnt;
	logic       snd_valid;
	logic       snd_kind;
	logic [5:0] snd_pre;
	logic [15:0] snd_rnti;
	logic [1:0] sts;

	assign next_cnt = {1'b0, st.tx_attempts} + 9'd1;

	always_comb begin
		nxt = st;
		snd_valid = 1'b0;
		snd_kind = rauh_pkg::KIND_PREAMBLE;
		snd_pre = '0;
		snd_rnti = '0;
		sts = rauh_pkg::ST_ACTED;
		unique case (evt.cmd)
			rauh_pkg::CMD_START: begin
				if (st.phase != rauh_pkg::PH_IDLE) begin
					sts = rauh_pkg::ST_WRONG_PHASE;
				end else begin
					nxt.tx_attempts = 8'd1;
					nxt.saved_ra_rnti = '0;
					nxt.saved_crnti = '0;
					nxt.phase = rauh_pkg::PH_WAIT_RESP;
					snd_valid = 1'b1;
					snd_pre = cfg.preamble_number;
				end
			end
			rauh_pkg::CMD_RESPONSE: begin
				if (st.phase != rauh_pkg::PH_WAIT_RESP) begin
					sts = rauh_pkg::ST_WRONG_PHASE;
				end else if (evt.event_rnti != cfg.expected_response_rnti) begin
					sts = rauh_pkg::ST_MISMATCH;
				end else begin
					nxt.saved_ra_rnti = evt.event_rnti;
					nxt.phase = rauh_pkg::PH_WAIT_RESOLVE;
					snd_valid = 1'b1;
					snd_kind = rauh_pkg::KIND_REQUEST;
					snd_rnti = evt.event_rnti;
				end
			end
			rauh_pkg::CMD_RESOLVE: begin
				if (st.phase != rauh_pkg::PH_WAIT_RESOLVE) begin
					sts = rauh_pkg::ST_WRONG_PHASE;
				end else if (evt.event_rnti != st.saved_ra_rnti) begin
					sts = rauh_pkg::ST_MISMATCH;
				end else begin
					nxt.saved_crnti = evt.granted_crnti;
					nxt.phase = rauh_pkg::PH_CONNECTED;
				end
			end
			rauh_pkg::CMD_RESP_TMO: begin
				if (st.phase != rauh_pkg::PH_WAIT_RESP) begin
					sts = rauh_pkg::ST_WRONG_PHASE;
				end else if (next_cnt <= {1'b0, cfg.max_preamble_sends}) begin
					nxt.tx_attempts = next_cnt[7:0];
					snd_valid = 1'b1;
					snd_pre = cfg.preamble_number;
				end else begin
					nxt.tx_attempts = '0;
					nxt.phase = rauh_pkg::PH_IDLE;
					sts = rauh_pkg::ST_EXHAUSTED;
				end
			end
			rauh_pkg::CMD_RESOLVE_TMO: begin
				if (st.phase != rauh_pkg::PH_WAIT_RESOLVE) begin
					sts = rauh_pkg::ST_WRONG_PHASE;
				end else begin
					nxt.phase = rauh_pkg::PH_IDLE;
				end
			end
			rauh_pkg::CMD_FORCE_IDLE: begin
				nxt.phase = rauh_pkg::PH_IDLE;
			end
			default: begin
				sts = rauh_pkg::ST_WRONG_PHASE;
			end
		endcase
	end

	always_comb begin
		res.send_valid = snd_valid;
		res.send_kind = snd_kind;
		res.send_preamble = snd_pre;
		res.send_rnti = snd_rnti;
		res.attempt_count = nxt.tx_attempts;
		res.state_changed = (nxt.phase != st.phase);
		res.prior_phase = st.phase;
		res.current_phase = nxt.phase;
		res.owned_crnti = nxt.saved_crnti;
		res.status = sts;
	end

endmodule
